// File: rtl/byte_ring_buffer_assert.svh
// Assertion macros used by the ring buffer checker.
`ifndef BYTE_RING_BUFFER_ASSERT_SVH
`define BYTE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BRB_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define BRB_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BRB_ASSERT_ALWAYS_NEXT(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/brb_pkg.sv
// Types and constants of the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;

  localparam int DATA_W     = 8;
  localparam int CNT_W      = 13;
  localparam int REQ_W      = 7;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 48;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CNT_W-1:0] RUN_MAX = 13'h1FFF;

  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] data;
    logic              run_end;
    logic [REQ_W-1:0]  req;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic              byte_valid;
    logic [DATA_W-1:0] out_byte;
    logic              last;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  free;
    logic [CNT_W-1:0]  used;
  } result_t;

  // output queue status seen by the back end
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } oq_status_t;

endpackage

// File: rtl/brb_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps
module brb_front import brb_pkg::*; #(
  parameter int MAX_READ = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  output cmd_t                 cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_pop
);

  localparam logic [REQ_W-1:0] MaxReq = REQ_W'(MAX_READ);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       in_cmd;
  logic [REQ_W-1:0] req_raw;

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    req_raw        = s_tdata[DATA_W +: REQ_W];
    in_cmd.is_read = (s_tuser == OP_READ);
    in_cmd.data    = s_tdata[DATA_W-1:0];
    in_cmd.run_end = s_tlast;
    in_cmd.req     = (req_raw > MaxReq) ? MaxReq : req_raw;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// File: rtl/brb_back.sv
// Back end: byte store, ring pointers, fill count and result issue.
`timescale 1ns / 1ps
module brb_back import brb_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  oq_status_t       oq,
  output logic             push,
  output result_t          push_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CapRst = (4096 > DEPTH) ? DEPTH : 4096;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;

  logic             st, st_next;
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    tail, tail_next;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    cap, cap_cfg;
  logic [CNT_W-1:0] run_acc, run_acc_next;
  logic [REQ_W-1:0] rem, rem_next;
  logic [REQ_W-1:0] moved, moved_next;
  logic             pend;
  result_t          pend_res;
  logic             issue;
  result_t          issue_res;
  logic             mem_we, mem_re;
  logic             room;
  logic [2:0]       occ;
  logic [REQ_W-1:0] n;
  logic [31:0]      nsel;
  logic [31:0]      capw;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [CW-1:0] c);
    logic [31:0] nx;
    nx = 32'(idx) + 32'd1;
    return (nx >= 32'(c)) ? '0 : nx[AW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[CNT_W-1:0];
  endfunction

  always_comb begin
    if (cfg_data == '0) capw = 32'd1;
    else if (32'(cfg_data) > DEPTH) capw = 32'(DEPTH);
    else capw = 32'(cfg_data);
    cap_cfg = capw[CW-1:0];
  end

  // a result issued now passes the pending result register before it lands in the output queue
  assign occ  = {1'b0, oq.count} + {2'b00, pend} - {2'b00, oq.pop};
  assign room = (occ <= 3'd1);

  always_comb begin
    nsel = (32'(cmd.req) < 32'(fill)) ? 32'(cmd.req) : 32'(fill);
    n    = nsel[REQ_W-1:0];
  end

  always_comb begin
    st_next      = st;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    run_acc_next = run_acc;
    rem_next     = rem;
    moved_next   = moved;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    issue        = 1'b0;
    issue_res    = '0;
    unique case (st)
      ST_IDLE: begin
        if (cmd_valid && room) begin
          cmd_pop = 1'b1;
          if (!cmd.is_read) begin
            if (fill < cap) begin
              mem_we    = 1'b1;
              tail_next = adv(tail, cap);
              fill_next = fill + 1'b1;
              if (run_acc != RUN_MAX) run_acc_next = run_acc + 1'b1;
            end
            if (cmd.run_end) begin
              issue           = 1'b1;
              issue_res.kind  = KIND_WRITE;
              issue_res.last  = 1'b1;
              issue_res.moved = run_acc_next;
              issue_res.free  = to_cnt(cap - fill_next);
              issue_res.used  = to_cnt(fill_next);
              run_acc_next    = '0;
            end
          end else if (n == '0) begin
            // nothing to read: one empty result
            issue          = 1'b1;
            issue_res.kind = KIND_READ;
            issue_res.last = 1'b1;
            issue_res.free = to_cnt(cap - fill);
            issue_res.used = to_cnt(fill);
          end else begin
            st_next    = ST_READ;
            rem_next   = n;
            moved_next = n;
            fill_next  = fill - CW'(n);
          end
        end
      end
      ST_READ: begin
        if (room) begin
          mem_re               = 1'b1;
          issue                = 1'b1;
          issue_res.kind       = KIND_READ;
          issue_res.byte_valid = 1'b1;
          issue_res.last       = (rem == REQ_W'(1));
          issue_res.moved      = CNT_W'(moved);
          issue_res.free       = to_cnt(cap - fill);
          issue_res.used       = to_cnt(fill);
          head_next            = adv(head, cap);
          rem_next             = rem - 1'b1;
          if (rem == REQ_W'(1)) st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[tail] <= cmd.data;
    if (mem_re) mem_q <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (issue) pend_res <= issue_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      run_acc <= '0;
      rem     <= '0;
      moved   <= '0;
      pend    <= 1'b0;
      cap     <= CW'(CapRst);
    end else if (cfg_we) begin
      // new size flushes the buffer
      st      <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      run_acc <= '0;
      pend    <= 1'b0;
      cap     <= cap_cfg;
    end else begin
      st      <= st_next;
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      run_acc <= run_acc_next;
      rem     <= rem_next;
      moved   <= moved_next;
      pend    <= issue;
    end
  end

  always_comb begin
    push              = pend;
    push_res          = pend_res;
    push_res.out_byte = pend_res.byte_valid ? mem_q : '0;
  end

endmodule

// File: rtl/brb_out_queue.sv
// Two-entry output queue that parts the back end from the receiver.
`timescale 1ns / 1ps
module brb_out_queue import brb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_res,
  output oq_status_t status,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    m_res
);

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign m_tvalid     = (count != 2'd0);
  assign pop          = m_tvalid && m_tready;
  assign m_res        = q[rd_ptr];
  assign status.count = count;
  assign status.pop   = pop;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/byte_ring_buffer.sv
// Top level of the byte ring buffer.
//
// Input stream (s_*): one word per command. s_tuser = 0 writes the byte in
// s_tdata, s_tlast closes a write run; s_tuser = 1 is a read request for
// s_tdata[14:8] bytes (saturated to MAX_READ). A write to a full buffer drops
// the byte. The word closing a run yields one report with the bytes accepted.
// Output stream (m_*): one word per result. A read gives one word per byte
// taken (m_tlast on the final one), or a single empty word if none is taken.
// Every result carries moved, free and used byte counts.
// With m_tready high, a write report or an empty read result passes the command
// queue, the pending result register and the output queue; the first byte of a
// read also passes the read state. A read gives one byte per cycle through the
// single read port of the byte store while the output queue has room.
// A two-entry command queue and a two-entry output queue let the input and
// output sides stall independently; when the receiver holds m_tready low the
// back end stops issuing and the input side fills its queue, then drops tready.
// Reset (rst, synchronous) empties the buffer and sets the size to 4096
// (limited to DEPTH). A cfg_we write sets the size and flushes the buffer.
`timescale 1ns / 1ps
module byte_ring_buffer import brb_pkg::*; #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte[7:0], read_count[14:8], zero[15]
  input  logic                 s_tuser,   // operation
  input  logic                 s_tlast,   // run_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // out_byte[7:0], moved_count[20:8],
                                          // free_bytes[33:21], used_bytes[46:34], zero[47]
  output logic [1:0]           m_tuser,   // kind[0], byte_valid[1]
  output logic                 m_tlast    // last
);

  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  oq_status_t oq;
  logic       push;
  result_t    push_res;
  result_t    m_res;

  brb_front #(.MAX_READ(MAX_READ)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  brb_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .oq        (oq),
    .push      (push),
    .push_res  (push_res)
  );

  brb_out_queue u_oq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .status   (oq),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {1'b0, m_res.used, m_res.free, m_res.moved, m_res.out_byte};
  assign m_tuser = {m_res.byte_valid, m_res.kind};
  assign m_tlast = m_res.last;

endmodule

// File: rtl/brb_checker.sv
// Port-level checks of the byte ring buffer, bound to the top level.
`timescale 1ns / 1ps
`include "byte_ring_buffer_assert.svh"
module brb_checker import brb_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser,
  input logic                 m_tlast
);

  `BRB_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `BRB_ASSERT_SAME(a_report, clk, rst, m_tvalid && (m_tuser[0] == KIND_WRITE), !m_tuser[1] && m_tlast, "write report not a single empty word")
  `BRB_ASSERT_SAME(a_empty, clk, rst, m_tvalid && !m_tuser[1], (m_tdata[7:0] == 8'd0) && m_tlast, "empty result carries a byte or is not last")
  `BRB_ASSERT_SAME(a_moved, clk, rst, m_tvalid && m_tuser[1], m_tdata[20:8] != 13'd0, "byte result reports zero moved")
  `BRB_ASSERT_ALWAYS_NEXT(a_rst, clk, rst, !m_tvalid, "output valid after reset")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the byte ring buffer: stream driver, monitor and shadow buffer.
`timescale 1ns / 1ps
module testbench;
  import brb_pkg::*;

  localparam int BUF_DEPTH   = 4096;
  localparam int READ_MAX    = 64;
  localparam int FULL_SIZE   = 20;
  localparam int DRAIN_WAIT  = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  byte_ring_buffer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // shadow copy of the buffer
  logic [7:0] shadow_bytes [BUF_DEPTH];
  int         cap = BUF_DEPTH;
  int         head_ptr = 0;
  int         tail_ptr = 0;
  int         fill = 0;
  int         run_bytes = 0;

  cmd_t       pending_words [$];
  result_t    expected_results [$];
  cmd_t       cur_word;

  int         send_idle = 0;
  int         stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stall_cycles = 0;

  int         errors = 0;
  int         words_in = 0;
  int         results_seen = 0;
  int         sizes_used = 0;
  int         dropped = 0;
  int         top_report = 0;

  function automatic result_t make_result(logic kind, logic valid, logic [7:0] b,
                                          logic last, int moved);
    result_t r;
    r.kind       = kind;
    r.byte_valid = valid;
    r.out_byte   = b;
    r.last       = last;
    r.moved      = moved[CNT_W-1:0];
    r.free       = CNT_W'(cap - fill);
    r.used       = CNT_W'(fill);
    return r;
  endfunction

  // expected results of one accepted word
  function automatic void apply_word(cmd_t w);
    int         req;
    int         n;
    int         i;
    logic [7:0] taken [READ_MAX];
    if (w.is_read == OP_WRITE) begin
      if (fill < cap) begin
        shadow_bytes[tail_ptr] = w.data;
        tail_ptr = (tail_ptr + 1 >= cap) ? 0 : tail_ptr + 1;
        fill++;
        if (run_bytes < int'(RUN_MAX)) run_bytes++;
      end else begin
        dropped++;
      end
      if (w.run_end) begin
        expected_results.push_back(make_result(KIND_WRITE, 1'b0, 8'h00, 1'b1, run_bytes));
        if (run_bytes > top_report) top_report = run_bytes;
        run_bytes = 0;
      end
    end else begin
      req = (int'(w.req) > READ_MAX) ? READ_MAX : int'(w.req);
      n = (req < fill) ? req : fill;
      if (n == 0) begin
        expected_results.push_back(make_result(KIND_READ, 1'b0, 8'h00, 1'b1, 0));
      end else begin
        for (i = 0; i < n; i++) begin
          taken[i] = shadow_bytes[head_ptr];
          head_ptr = (head_ptr + 1 >= cap) ? 0 : head_ptr + 1;
        end
        fill -= n;
        for (i = 0; i < n; i++)
          expected_results.push_back(make_result(KIND_READ, 1'b1, taken[i],
                                                 (i + 1 == n), n));
      end
    end
  endfunction

  // driver: holds a word until taken, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_word(cur_word);
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, cur_word.req, cur_word.data};
          s_tuser  <= cur_word.is_read;
          s_tlast  <= cur_word.run_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic string show(result_t r);
    return $sformatf("kind %0d valid %0d byte %02h last %0d moved %0d free %0d used %0d",
                     r.kind, r.byte_valid, r.out_byte, r.last, r.moved, r.free, r.used);
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind       = m_tuser[0];
      got.byte_valid = m_tuser[1];
      got.out_byte   = m_tdata[7:0];
      got.last       = m_tlast;
      got.moved      = m_tdata[20:8];
      got.free       = m_tdata[33:21];
      got.used       = m_tdata[46:34];
      results_seen++;
      if (expected_results.size() == 0) begin
        note_error($sformatf("result %0d not expected: %s", results_seen, show(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          note_error($sformatf("result %0d: expected %s, got %s",
                               results_seen, show(want), show(got)));
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic cmd_t wr_word(logic [7:0] d, logic last_byte);
    cmd_t c;
    c.is_read = OP_WRITE;
    c.data    = d;
    c.run_end = last_byte;
    c.req     = REQ_W'($urandom_range(127));
    return c;
  endfunction

  function automatic cmd_t rd_word(int n);
    cmd_t c;
    c.is_read = OP_READ;
    c.data    = 8'($urandom_range(255));
    c.run_end = 1'($urandom_range(1));
    c.req     = REQ_W'(n);
    return c;
  endfunction

  // no words queued, none in flight, nothing owed; then let trailing writes settle
  task automatic wait_drained();
    int n;
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
    for (n = 0; n < DRAIN_WAIT; n++) @(negedge clk);
  endtask

  task automatic set_size(int v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CNT_W'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap       = (v == 0) ? 1 : ((v > BUF_DEPTH) ? BUF_DEPTH : v);
    head_ptr  = 0;
    tail_ptr  = 0;
    fill      = 0;
    run_bytes = 0;
    sizes_used++;
  endtask

  // mostly whole write runs and reads, some stray words
  task automatic gen_random(int count);
    int k;
    int len;
    int i;
    int r;
    k = 0;
    while (k < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(1, 12);
        for (i = 0; i < len; i++)
          pending_words.push_back(wr_word(8'($urandom_range(255)), i == len - 1));
        k += len;
      end else if (r < 85) begin
        pending_words.push_back(rd_word($urandom_range(1, READ_MAX)));
        k++;
      end else if (r < 93) begin
        pending_words.push_back(wr_word(8'($urandom_range(255)), 1'($urandom_range(1))));
        k++;
      end else begin
        pending_words.push_back(rd_word($urandom_range(127)));
        k++;
      end
    end
  endtask

  task automatic run_phase(int idle, int stall, int size, int count, bit squeeze);
    wait_drained();
    set_size(size);
    send_idle = idle;
    stall_pct = stall;
    if (squeeze) hold_req++;
    gen_random(count);
    wait_drained();
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset size
    pending_words.push_back(rd_word(1));
    pending_words.push_back(rd_word(0));
    pending_words.push_back(wr_word(8'h00, 1'b1));
    pending_words.push_back(wr_word(8'hFF, 1'b0));
    pending_words.push_back(wr_word(8'hA5, 1'b0));
    pending_words.push_back(wr_word(8'h5A, 1'b1));
    pending_words.push_back(rd_word(127));
    pending_words.push_back(wr_word(8'h01, 1'b0));
    pending_words.push_back(wr_word(8'h80, 1'b0));
    pending_words.push_back(wr_word(8'h7F, 1'b0));
    pending_words.push_back(rd_word(2));
    pending_words.push_back(rd_word(0));
    pending_words.push_back(rd_word(65));
    pending_words.push_back(wr_word(8'hC3, 1'b1));
    pending_words.push_back(rd_word(READ_MAX));
    wait_drained();

    // one-slot buffer: drops into a full buffer
    set_size(1);
    pending_words.push_back(wr_word(8'h11, 1'b0));
    pending_words.push_back(wr_word(8'h22, 1'b1));
    pending_words.push_back(wr_word(8'h33, 1'b1));
    pending_words.push_back(wr_word(8'h44, 1'b0));
    pending_words.push_back(rd_word(1));
    pending_words.push_back(rd_word(1));
    pending_words.push_back(wr_word(8'h55, 1'b1));
    pending_words.push_back(rd_word(READ_MAX));
    wait_drained();

    // fill a small buffer past full, then drain it
    set_size(FULL_SIZE);
    for (i = 0; i <= FULL_SIZE; i++)
      pending_words.push_back(wr_word(8'($urandom_range(255)), i == FULL_SIZE));
    pending_words.push_back(wr_word(8'hE7, 1'b1));
    pending_words.push_back(rd_word(READ_MAX));
    pending_words.push_back(rd_word(1));
    wait_drained();

    run_phase(0, 0, 0, 20, 1'b0);
    run_phase(0, 0, 200, 35, 1'b1);
    run_phase(83, 0, 17, 30, 1'b0);
    run_phase(83, 0, 8191, 30, 1'b0);
    run_phase(0, 83, 3, 30, 1'b0);
    run_phase(0, 83, READ_MAX, 30, 1'b0);
    run_phase(18, 18, BUF_DEPTH, 30, 1'b0);
    run_phase(18, 18, 29, 30, 1'b0);

    $display("covered %0d input words and %0d checked results over %0d buffer sizes",
             words_in, results_seen, sizes_used);
    $display("%0d bytes dropped on a full buffer, largest run report %0d",
             dropped, top_report);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
